[src/dmarb_pkg.sv]
package dmarb_pkg;

    // run counter width and the width used to compare it against hold_ticks
    localparam int COUNTER_BITS = 8;
    localparam int HOLD_W       = 8;
    localparam int CMP_W        = (COUNTER_BITS > HOLD_W) ? COUNTER_BITS : HOLD_W;

    // field widths
    localparam int CONF_W  = 11;
    localparam int SPEED_W = 16;
    localparam int TTC_W   = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CONF_EXIT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CONF_RETURN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TICKS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_SPEED = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_SPEED  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TTC_STOP    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_NARROW_SPEED = 3'd6;

    // configuration reset values
    localparam logic [CONF_W-1:0]  RST_CONF_EXIT    = 11'd400;
    localparam logic [CONF_W-1:0]  RST_CONF_RETURN  = 11'd700;
    localparam logic [HOLD_W-1:0]  RST_HOLD_TICKS   = 8'd5;
    localparam logic [SPEED_W-1:0] RST_ACCEL_SPEED  = 16'd300;
    localparam logic [SPEED_W-1:0] RST_BASE_SPEED   = 16'd150;
    localparam logic [TTC_W-1:0]   RST_TTC_STOP     = 16'd150;
    localparam logic [SPEED_W-1:0] RST_NARROW_SPEED = 16'd80;

    typedef enum logic [1:0] {
        MODE_LANE     = 2'd0,
        MODE_WAYPOINT = 2'd1,
        MODE_AVOID    = 2'd2,
        MODE_PARKING  = 2'd3
    } mode_t;

    // return mode after avoid: lane or waypoint
    localparam logic RET_LANE     = 1'b0;
    localparam logic RET_WAYPOINT = 1'b1;

    typedef struct packed {
        logic [CONF_W-1:0]  conf_exit_level;
        logic [CONF_W-1:0]  conf_return_level;
        logic [HOLD_W-1:0]  hold_ticks;
        logic [SPEED_W-1:0] accel_speed;
        logic [SPEED_W-1:0] base_speed;
        logic [TTC_W-1:0]   ttc_stop_level;
        logic [SPEED_W-1:0] narrow_gap_speed;
    } cfg_t;

    typedef struct packed {
        logic [CONF_W-1:0]  lane_confidence;
        logic [1:0]         zone_flags;
        logic [3:0]         avoid_flags;
        logic [2:0]         parking_flags;
        logic               emergency_stop;
        logic               traffic_stop;
        logic [TTC_W-1:0]   time_to_collision;
        logic [SPEED_W-1:0] avoid_speed;
        logic [SPEED_W-1:0] parking_speed;
    } item_t;

    typedef struct packed {
        mode_t              mode;
        logic [SPEED_W-1:0] speed_ref;
        logic               hard_stop;
    } result_t;

endpackage

[src/driving_mode_arbiter_top.sv]
// driving mode arbiter
// input channel: one sensor snapshot per transaction (in_valid / in_ready),
//   one snapshot per control tick
// output channel: one result per snapshot (out_valid / out_ready) carrying
//   mode, speed_ref and hard_stop
// configuration: cfg_we writes cfg_data into register cfg_index (0..6) at the
//   clock edge, no wait; indexes above 6 are ignored; write only while idle
// latency: a snapshot taken at edge N is decided between the input register
//   and the result register and is presented after edge N+1 when the result
//   register is free
// throughput: one transaction per cycle, set by the single decision stage
//   (counter update, mode transition, speed priority) between the registers
// stall: when out_ready is low the result holds, the input register keeps one
//   more snapshot, and in_ready drops only once both are full
// reset: rst_n (async, active low) clears both valids, sets lane mode with
//   lane as return mode, zeroes both run counters and loads default registers
module driving_mode_arbiter_top (
    input  logic                               clk,
    input  logic                               rst_n,
    // configuration port
    input  logic                               cfg_we,
    input  logic [dmarb_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [dmarb_pkg::CFG_DATA_W-1:0]   cfg_data,
    // input channel
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [dmarb_pkg::CONF_W-1:0]       lane_confidence,
    input  logic [1:0]                         zone_flags,
    input  logic [3:0]                         avoid_flags,
    input  logic [2:0]                         parking_flags,
    input  logic                               emergency_stop,
    input  logic                               traffic_stop,
    input  logic [dmarb_pkg::TTC_W-1:0]        time_to_collision,
    input  logic [dmarb_pkg::SPEED_W-1:0]      avoid_speed,
    input  logic [dmarb_pkg::SPEED_W-1:0]      parking_speed,
    // output channel
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [1:0]                         mode,
    output logic [dmarb_pkg::SPEED_W-1:0]      speed_ref,
    output logic                               hard_stop
);

    dmarb_pkg::cfg_t    cfg;
    dmarb_pkg::item_t   in_item;
    dmarb_pkg::item_t   item_reg;
    dmarb_pkg::result_t core_result;
    dmarb_pkg::result_t result_reg;

    logic item_valid_reg;
    logic item_valid_next;
    logic out_valid_reg;
    logic out_valid_next;
    logic out_free;
    logic step;
    logic in_take;

    dmarb_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // pack the incoming snapshot
    always_comb
    begin
        in_item.lane_confidence   = lane_confidence;
        in_item.zone_flags        = zone_flags;
        in_item.avoid_flags       = avoid_flags;
        in_item.parking_flags     = parking_flags;
        in_item.emergency_stop    = emergency_stop;
        in_item.traffic_stop      = traffic_stop;
        in_item.time_to_collision = time_to_collision;
        in_item.avoid_speed       = avoid_speed;
        in_item.parking_speed     = parking_speed;
    end

    // pipeline flow control
    assign out_free = !out_valid_reg || out_ready;
    assign step     = item_valid_reg && out_free;
    assign in_ready = !item_valid_reg || out_free;
    assign in_take  = in_valid && in_ready;

    assign item_valid_next = in_take || (item_valid_reg && !step);
    assign out_valid_next  = step || (out_valid_reg && !out_ready);

    dmarb_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .item   (item_reg),
        .cfg    (cfg),
        .result (core_result)
    );

    // valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
            item_reg <= in_item;
        if (step)
            result_reg <= core_result;
    end

    assign out_valid = out_valid_reg;
    assign mode      = result_reg.mode;
    assign speed_ref = result_reg.speed_ref;
    assign hard_stop = result_reg.hard_stop;

endmodule

[src/dmarb_cfg_regs.sv]
module dmarb_cfg_regs (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [dmarb_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [dmarb_pkg::CFG_DATA_W-1:0]   cfg_data,
    output dmarb_pkg::cfg_t                    cfg
);

    dmarb_pkg::cfg_t cfg_reg;
    dmarb_pkg::cfg_t cfg_next;

    // decode a register write, truncating data to the register width
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                dmarb_pkg::CFG_CONF_EXIT:
                    cfg_next.conf_exit_level = cfg_data[dmarb_pkg::CONF_W-1:0];
                dmarb_pkg::CFG_CONF_RETURN:
                    cfg_next.conf_return_level = cfg_data[dmarb_pkg::CONF_W-1:0];
                dmarb_pkg::CFG_HOLD_TICKS:
                    cfg_next.hold_ticks = cfg_data[dmarb_pkg::HOLD_W-1:0];
                dmarb_pkg::CFG_ACCEL_SPEED:
                    cfg_next.accel_speed = cfg_data[dmarb_pkg::SPEED_W-1:0];
                dmarb_pkg::CFG_BASE_SPEED:
                    cfg_next.base_speed = cfg_data[dmarb_pkg::SPEED_W-1:0];
                dmarb_pkg::CFG_TTC_STOP:
                    cfg_next.ttc_stop_level = cfg_data[dmarb_pkg::TTC_W-1:0];
                dmarb_pkg::CFG_NARROW_SPEED:
                    cfg_next.narrow_gap_speed = cfg_data[dmarb_pkg::SPEED_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    // register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.conf_exit_level   <= dmarb_pkg::RST_CONF_EXIT;
            cfg_reg.conf_return_level <= dmarb_pkg::RST_CONF_RETURN;
            cfg_reg.hold_ticks        <= dmarb_pkg::RST_HOLD_TICKS;
            cfg_reg.accel_speed       <= dmarb_pkg::RST_ACCEL_SPEED;
            cfg_reg.base_speed        <= dmarb_pkg::RST_BASE_SPEED;
            cfg_reg.ttc_stop_level    <= dmarb_pkg::RST_TTC_STOP;
            cfg_reg.narrow_gap_speed  <= dmarb_pkg::RST_NARROW_SPEED;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[src/dmarb_core.sv]
module dmarb_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  dmarb_pkg::item_t     item,
    input  dmarb_pkg::cfg_t      cfg,
    output dmarb_pkg::result_t   result
);

    localparam logic [dmarb_pkg::COUNTER_BITS-1:0] CNT_MAX = '1;

    dmarb_pkg::mode_t                     mode_reg;
    dmarb_pkg::mode_t                     mode_next;
    logic                                 ret_reg;
    logic                                 ret_next;
    logic [dmarb_pkg::COUNTER_BITS-1:0]   low_cnt_reg;
    logic [dmarb_pkg::COUNTER_BITS-1:0]   low_cnt_next;
    logic [dmarb_pkg::COUNTER_BITS-1:0]   high_cnt_reg;
    logic [dmarb_pkg::COUNTER_BITS-1:0]   high_cnt_next;

    logic low_hit;
    logic high_hit;
    logic low_held;
    logic high_held;
    logic park_area;
    logic accel_area;
    logic obstacle;
    logic avoidable;
    logic man_done;
    logic narrow;
    logic spot_free;
    logic park_done;
    logic blocked;
    logic ttc_low;
    logic [dmarb_pkg::CMP_W-1:0] hold_ext;

    // flag decode
    assign park_area    = item.zone_flags[0];
    assign accel_area   = item.zone_flags[1];
    assign obstacle     = item.avoid_flags[0];
    assign avoidable    = item.avoid_flags[1];
    assign man_done     = item.avoid_flags[2];
    assign narrow       = item.avoid_flags[3];
    assign spot_free    = item.parking_flags[0];
    assign park_done    = item.parking_flags[1];
    assign blocked      = item.parking_flags[2];
    assign ttc_low      = item.time_to_collision < cfg.ttc_stop_level;

    // saturating hysteresis counters
    assign low_hit  = item.lane_confidence < cfg.conf_exit_level;
    assign high_hit = item.lane_confidence > cfg.conf_return_level;

    always_comb
    begin
        if (!low_hit)
            low_cnt_next = '0;
        else if (low_cnt_reg == CNT_MAX)
            low_cnt_next = low_cnt_reg;
        else
            low_cnt_next = low_cnt_reg + 1'b1;

        if (!high_hit)
            high_cnt_next = '0;
        else if (high_cnt_reg == CNT_MAX)
            high_cnt_next = high_cnt_reg;
        else
            high_cnt_next = high_cnt_reg + 1'b1;
    end

    assign hold_ext  = dmarb_pkg::CMP_W'(cfg.hold_ticks);
    assign low_held  = dmarb_pkg::CMP_W'(low_cnt_next) >= hold_ext;
    assign high_held = dmarb_pkg::CMP_W'(high_cnt_next) >= hold_ext;

    // mode transition
    always_comb
    begin
        mode_next = mode_reg;
        ret_next  = ret_reg;
        unique case (mode_reg)
            dmarb_pkg::MODE_LANE:
            begin
                priority if (park_area && spot_free)
                    mode_next = dmarb_pkg::MODE_PARKING;
                else if (obstacle && avoidable)
                begin
                    mode_next = dmarb_pkg::MODE_AVOID;
                    ret_next  = dmarb_pkg::RET_LANE;
                end
                else if (low_held)
                    mode_next = dmarb_pkg::MODE_WAYPOINT;
                else
                    mode_next = mode_reg;
            end
            dmarb_pkg::MODE_WAYPOINT:
            begin
                priority if (obstacle && avoidable)
                begin
                    mode_next = dmarb_pkg::MODE_AVOID;
                    ret_next  = dmarb_pkg::RET_WAYPOINT;
                end
                else if (high_held)
                    mode_next = dmarb_pkg::MODE_LANE;
                else
                    mode_next = mode_reg;
            end
            dmarb_pkg::MODE_AVOID:
            begin
                if (man_done)
                    mode_next = (ret_reg == dmarb_pkg::RET_WAYPOINT) ?
                                dmarb_pkg::MODE_WAYPOINT : dmarb_pkg::MODE_LANE;
            end
            dmarb_pkg::MODE_PARKING:
            begin
                if (park_done)
                    mode_next = dmarb_pkg::MODE_LANE;
            end
            default:
                mode_next = mode_reg;
        endcase
    end

    // speed selection for the new mode
    always_comb
    begin
        result.mode      = mode_next;
        result.speed_ref = '0;
        result.hard_stop = 1'b0;
        unique case (mode_next)
            dmarb_pkg::MODE_LANE,
            dmarb_pkg::MODE_WAYPOINT:
            begin
                priority if (item.emergency_stop)
                    result.hard_stop = 1'b1;
                else if (item.traffic_stop)
                    result.speed_ref = '0;
                else if (accel_area)
                    result.speed_ref = cfg.accel_speed;
                else
                    result.speed_ref = cfg.base_speed;
            end
            dmarb_pkg::MODE_AVOID:
            begin
                priority if (item.emergency_stop || ttc_low)
                    result.hard_stop = 1'b1;
                else if (narrow && (cfg.narrow_gap_speed < item.avoid_speed))
                    result.speed_ref = cfg.narrow_gap_speed;
                else
                    result.speed_ref = item.avoid_speed;
            end
            dmarb_pkg::MODE_PARKING:
            begin
                priority if (item.emergency_stop)
                    result.hard_stop = 1'b1;
                else if (blocked)
                    result.speed_ref = '0;
                else
                    result.speed_ref = item.parking_speed;
            end
            default:
                result.speed_ref = '0;
        endcase
    end

    // state registers, advanced once per transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= dmarb_pkg::MODE_LANE;
            ret_reg      <= dmarb_pkg::RET_LANE;
            low_cnt_reg  <= '0;
            high_cnt_reg <= '0;
        end
        else if (step)
        begin
            mode_reg     <= mode_next;
            ret_reg      <= ret_next;
            low_cnt_reg  <= low_cnt_next;
            high_cnt_reg <= high_cnt_next;
        end
    end

endmodule

[verif/tb_driving_mode_arbiter_top.sv]
`timescale 1ns / 1ps

module tb_driving_mode_arbiter_top;
    import dmarb_pkg::*;

    // flag bits of the snapshot
    localparam logic [1:0] ZF_PARK       = 2'b01;
    localparam logic [1:0] ZF_ACCEL      = 2'b10;
    localparam logic [3:0] AVF_OBSTACLE  = 4'b0001;
    localparam logic [3:0] AVF_AVOIDABLE = 4'b0010;
    localparam logic [3:0] AVF_DONE      = 4'b0100;
    localparam logic [3:0] AVF_NARROW    = 4'b1000;
    localparam logic [2:0] PF_SPACE      = 3'b001;
    localparam logic [2:0] PF_DONE       = 3'b010;
    localparam logic [2:0] PF_BLOCKED    = 3'b100;

    // register index with no register behind it
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

    localparam logic [COUNTER_BITS-1:0] RUN_MAX = '1;
    localparam int LONG_HOLD  = 60;
    localparam int IDLE_TAIL  = 4;
    localparam int PHASE_SIZE = 170;

    typedef enum int {CONF_LOW, CONF_HIGH, CONF_BETWEEN, CONF_ANY} conf_band_t;
    typedef enum int {RX_ALWAYS, RX_MOSTLY, RX_SPARSE, RX_TOGGLE} rx_style_t;

    typedef struct {
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
    } reg_write_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic in_valid;
    logic in_ready;
    logic [CONF_W-1:0] lane_confidence;
    logic [1:0] zone_flags;
    logic [3:0] avoid_flags;
    logic [2:0] parking_flags;
    logic emergency_stop;
    logic traffic_stop;
    logic [TTC_W-1:0] time_to_collision;
    logic [SPEED_W-1:0] avoid_speed;
    logic [SPEED_W-1:0] parking_speed;
    logic out_valid;
    logic out_ready;
    logic [1:0] mode;
    logic [SPEED_W-1:0] speed_ref;
    logic hard_stop;

    // arbiter shadow: registers and state
    cfg_t arb_regs;
    mode_t arb_mode;
    logic arb_return;
    logic [COUNTER_BITS-1:0] low_run;
    logic [COUNTER_BITS-1:0] high_run;

    result_t pending_results[$];
    reg_write_t reg_writes[$];
    int error_count;

    // sender pacing
    int tx_burst_left;
    bit tx_steady;

    // receiver pacing
    int hold_asked;
    int hold_served;
    int rx_hold_left;
    int rx_left;
    rx_style_t rx_style;

    driving_mode_arbiter_top dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .lane_confidence   (lane_confidence),
        .zone_flags        (zone_flags),
        .avoid_flags       (avoid_flags),
        .parking_flags     (parking_flags),
        .emergency_stop    (emergency_stop),
        .traffic_stop      (traffic_stop),
        .time_to_collision (time_to_collision),
        .avoid_speed       (avoid_speed),
        .parking_speed     (parking_speed),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .mode              (mode),
        .speed_ref         (speed_ref),
        .hard_stop         (hard_stop)
    );

    always #5 clk = ~clk;

    // run counters, mode transition, then speed priority for the new mode
    function automatic result_t step_arbiter(input item_t s);
        result_t r;
        logic steer_away;
        steer_away = ((s.avoid_flags & AVF_OBSTACLE) != 0)
                  && ((s.avoid_flags & AVF_AVOIDABLE) != 0);
        if (s.lane_confidence < arb_regs.conf_exit_level)
            low_run = (low_run == RUN_MAX) ? RUN_MAX : low_run + 1'b1;
        else
            low_run = '0;
        if (s.lane_confidence > arb_regs.conf_return_level)
            high_run = (high_run == RUN_MAX) ? RUN_MAX : high_run + 1'b1;
        else
            high_run = '0;

        case (arb_mode)
            MODE_LANE:
            begin
                if (((s.zone_flags & ZF_PARK) != 0) && ((s.parking_flags & PF_SPACE) != 0))
                    arb_mode = MODE_PARKING;
                else if (steer_away)
                begin
                    arb_return = RET_LANE;
                    arb_mode = MODE_AVOID;
                end
                else if (low_run >= arb_regs.hold_ticks)
                    arb_mode = MODE_WAYPOINT;
            end
            MODE_WAYPOINT:
            begin
                if (steer_away)
                begin
                    arb_return = RET_WAYPOINT;
                    arb_mode = MODE_AVOID;
                end
                else if (high_run >= arb_regs.hold_ticks)
                    arb_mode = MODE_LANE;
            end
            MODE_AVOID:
            begin
                if ((s.avoid_flags & AVF_DONE) != 0)
                    arb_mode = (arb_return == RET_WAYPOINT) ? MODE_WAYPOINT : MODE_LANE;
            end
            default:
            begin
                if ((s.parking_flags & PF_DONE) != 0)
                    arb_mode = MODE_LANE;
            end
        endcase

        r.mode = arb_mode;
        r.speed_ref = '0;
        r.hard_stop = 1'b0;
        case (arb_mode)
            MODE_LANE, MODE_WAYPOINT:
            begin
                if (s.emergency_stop)
                    r.hard_stop = 1'b1;
                else if (s.traffic_stop)
                    r.speed_ref = '0;
                else if ((s.zone_flags & ZF_ACCEL) != 0)
                    r.speed_ref = arb_regs.accel_speed;
                else
                    r.speed_ref = arb_regs.base_speed;
            end
            MODE_AVOID:
            begin
                if (s.emergency_stop || (s.time_to_collision < arb_regs.ttc_stop_level))
                    r.hard_stop = 1'b1;
                else if ((s.avoid_flags & AVF_NARROW) != 0)
                    r.speed_ref = (s.avoid_speed < arb_regs.narrow_gap_speed)
                                ? s.avoid_speed : arb_regs.narrow_gap_speed;
                else
                    r.speed_ref = s.avoid_speed;
            end
            default:
            begin
                if (s.emergency_stop)
                    r.hard_stop = 1'b1;
                else if ((s.parking_flags & PF_BLOCKED) != 0)
                    r.speed_ref = '0;
                else
                    r.speed_ref = s.parking_speed;
            end
        endcase
        return r;
    endfunction

    function automatic item_t snap(input int conf, input logic [1:0] zf, input logic [3:0] avf,
                                   input logic [2:0] pf, input bit es, input bit ts,
                                   input int ttc, input int avs, input int pks);
        item_t s;
        s.lane_confidence   = CONF_W'(conf);
        s.zone_flags        = zf;
        s.avoid_flags       = avf;
        s.parking_flags     = pf;
        s.emergency_stop    = es;
        s.traffic_stop      = ts;
        s.time_to_collision = TTC_W'(ttc);
        s.avoid_speed       = SPEED_W'(avs);
        s.parking_speed     = SPEED_W'(pks);
        return s;
    endfunction

    function automatic bit chance(input int pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    // value a few counts either side of a threshold
    function automatic int near(input int level);
        int v;
        v = level + $urandom_range(0, 6) - 3;
        if (v < 0)
            v = 0;
        if (v > 65535)
            v = 65535;
        return v;
    endfunction

    function automatic item_t noise_snapshot();
        item_t s;
        s.lane_confidence   = CONF_W'($urandom);
        s.zone_flags        = 2'($urandom);
        s.avoid_flags       = 4'($urandom);
        s.parking_flags     = 3'($urandom);
        s.emergency_stop    = 1'($urandom);
        s.traffic_stop      = 1'($urandom);
        s.time_to_collision = TTC_W'($urandom);
        s.avoid_speed       = SPEED_W'($urandom);
        s.parking_speed     = SPEED_W'($urandom);
        return s;
    endfunction

    // plausible snapshot with confidence held in one band
    function automatic item_t random_snapshot(input conf_band_t band);
        item_t s;
        int lo;
        int hi;
        lo = int'(arb_regs.conf_exit_level);
        hi = int'(arb_regs.conf_return_level);
        s = noise_snapshot();
        case (band)
            CONF_LOW:
                s.lane_confidence = (lo == 0) ? '0 : CONF_W'($urandom_range(0, lo - 1));
            CONF_HIGH:
                s.lane_confidence = (hi >= 2047) ? '1 : CONF_W'($urandom_range(hi + 1, 2047));
            CONF_BETWEEN:
                if (lo <= hi)
                    s.lane_confidence = CONF_W'($urandom_range(lo, hi));
            default:
                s.lane_confidence = chance(10) ? CONF_W'(1024) : CONF_W'($urandom_range(0, 1024));
        endcase
        s.zone_flags    = (chance(40) ? ZF_PARK : 2'b00) | (chance(50) ? ZF_ACCEL : 2'b00);
        s.avoid_flags   = (chance(15) ? AVF_OBSTACLE : 4'b0) | (chance(50) ? AVF_AVOIDABLE : 4'b0)
                        | (chance(15) ? AVF_DONE : 4'b0) | (chance(50) ? AVF_NARROW : 4'b0);
        s.parking_flags = (chance(15) ? PF_SPACE : 3'b0) | (chance(15) ? PF_DONE : 3'b0)
                        | (chance(30) ? PF_BLOCKED : 3'b0);
        s.emergency_stop = chance(5);
        s.traffic_stop   = chance(20);
        if (chance(50))
            s.time_to_collision = TTC_W'(near(int'(arb_regs.ttc_stop_level)));
        if (chance(50))
            s.avoid_speed = SPEED_W'(near(int'(arb_regs.narrow_gap_speed)));
        return s;
    endfunction

    // one snapshot transaction, with burst/gap pacing
    task automatic send_snapshot(input item_t s);
        int gap;
        if (tx_burst_left == 0 && !tx_steady)
        begin
            gap = $urandom_range(1, 6);
            tx_burst_left = $urandom_range(1, 24);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        if (tx_burst_left > 0)
            tx_burst_left--;
        in_valid          <= 1'b1;
        lane_confidence   <= s.lane_confidence;
        zone_flags        <= s.zone_flags;
        avoid_flags       <= s.avoid_flags;
        parking_flags     <= s.parking_flags;
        emergency_stop    <= s.emergency_stop;
        traffic_stop      <= s.traffic_stop;
        time_to_collision <= s.time_to_collision;
        avoid_speed       <= s.avoid_speed;
        parking_speed     <= s.parking_speed;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_results.push_back(step_arbiter(s));
    endtask

    // stop offering and wait for every expected result
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (IDLE_TAIL) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int data);
        reg_write_t w;
        w.idx = idx;
        w.data = CFG_DATA_W'(data);
        reg_writes.push_back(w);
    endtask

    // drive queued register writes, one per cycle, and mirror them
    task automatic commit_writes();
        reg_write_t w;
        while (reg_writes.size() != 0)
        begin
            w = reg_writes.pop_front();
            cfg_we    <= 1'b1;
            cfg_index <= w.idx;
            cfg_data  <= w.data;
            @(posedge clk);
            case (w.idx)
                CFG_CONF_EXIT:    arb_regs.conf_exit_level   = w.data[CONF_W-1:0];
                CFG_CONF_RETURN:  arb_regs.conf_return_level = w.data[CONF_W-1:0];
                CFG_HOLD_TICKS:   arb_regs.hold_ticks        = w.data[HOLD_W-1:0];
                CFG_ACCEL_SPEED:  arb_regs.accel_speed       = w.data[SPEED_W-1:0];
                CFG_BASE_SPEED:   arb_regs.base_speed        = w.data[SPEED_W-1:0];
                CFG_TTC_STOP:     arb_regs.ttc_stop_level    = w.data[TTC_W-1:0];
                CFG_NARROW_SPEED: arb_regs.narrow_gap_speed  = w.data[SPEED_W-1:0];
                default: ;
            endcase
        end
        cfg_we <= 1'b0;
    endtask

    task automatic write_all_regs(input int v_exit, input int v_ret, input int v_hold,
                                  input int v_accel, input int v_base, input int v_ttc,
                                  input int v_gap_cap);
        write_reg(CFG_CONF_EXIT, v_exit);
        write_reg(CFG_CONF_RETURN, v_ret);
        write_reg(CFG_HOLD_TICKS, v_hold);
        write_reg(CFG_ACCEL_SPEED, v_accel);
        write_reg(CFG_BASE_SPEED, v_base);
        write_reg(CFG_TTC_STOP, v_ttc);
        write_reg(CFG_NARROW_SPEED, v_gap_cap);
        commit_writes();
    endtask

    // every mode, every speed rule and the field extremes at reset settings
    task automatic test_directed_modes();
        int i;
        write_all_regs(400, 700, 5, 300, 150, 150, 80);
        send_snapshot(snap(0, 2'b00, 4'b0, 3'b0, 0, 0, 0, 0, 0));
        send_snapshot(snap(1024, 2'b00, 4'b0, 3'b0, 1, 1, 65535, 65535, 65535));
        send_snapshot(snap(2047, ZF_ACCEL, 4'b0, 3'b0, 0, 1, 0, 0, 0));
        send_snapshot(snap(1024, ZF_ACCEL, 4'b0, 3'b0, 0, 0, 0, 0, 0));
        // lane to parking and the parking speed rules
        send_snapshot(snap(500, ZF_PARK | ZF_ACCEL, 4'b0, PF_SPACE, 0, 0, 0, 0, 65535));
        send_snapshot(snap(500, 2'b00, 4'b0, PF_BLOCKED, 0, 0, 0, 0, 1234));
        send_snapshot(snap(500, 2'b00, 4'b0, PF_BLOCKED, 1, 0, 0, 0, 1234));
        send_snapshot(snap(500, 2'b00, 4'b0, 3'b0, 0, 0, 0, 0, 0));
        send_snapshot(snap(500, 2'b00, 4'b0, PF_DONE, 0, 0, 0, 0, 77));
        // lane to avoid and the avoid speed rules
        send_snapshot(snap(500, 2'b00, AVF_OBSTACLE, 3'b0, 0, 0, 65535, 500, 0));
        send_snapshot(snap(500, 2'b00, AVF_OBSTACLE | AVF_AVOIDABLE, 3'b0, 0, 0, 0, 500, 0));
        send_snapshot(snap(500, 2'b00, 4'b0, 3'b0, 0, 0, 149, 500, 0));
        send_snapshot(snap(500, 2'b00, 4'b0, 3'b0, 0, 0, 150, 0, 0));
        send_snapshot(snap(500, 2'b00, 4'b0, 3'b0, 0, 0, 65535, 65535, 0));
        send_snapshot(snap(500, 2'b00, AVF_NARROW, 3'b0, 0, 0, 65535, 79, 0));
        send_snapshot(snap(500, 2'b00, AVF_NARROW, 3'b0, 0, 0, 65535, 65535, 0));
        send_snapshot(snap(500, 2'b00, 4'b0, 3'b0, 1, 0, 65535, 300, 0));
        send_snapshot(snap(500, 2'b00, AVF_DONE, 3'b0, 0, 0, 65535, 300, 0));
        // low confidence run to waypoint, detour and back, high run to lane
        for (i = 0; i < 5; i++)
            send_snapshot(snap(0, 2'b00, 4'b0, 3'b0, 0, 0, 0, 0, 0));
        send_snapshot(snap(399, 2'b00, AVF_OBSTACLE | AVF_AVOIDABLE, 3'b0, 0, 0, 200, 90, 0));
        send_snapshot(snap(400, 2'b00, AVF_DONE, 3'b0, 0, 0, 200, 90, 0));
        for (i = 0; i < 5; i++)
            send_snapshot(snap(2047, ZF_ACCEL, 4'b0, 3'b0, 0, 0, 0, 0, 0));
        wait_idle();
    endtask

    // unused index, data wider than the register, zero hold ticks
    task automatic test_register_masking();
        int i;
        write_reg(CFG_UNUSED, 16'h0000);
        write_reg(CFG_HOLD_TICKS, 16'hFF00);
        write_reg(CFG_CONF_EXIT, 16'hFFFF);
        write_reg(CFG_CONF_RETURN, 16'hF800);
        commit_writes();
        for (i = 0; i < 6; i++)
            send_snapshot(snap((i == 5) ? 2047 : 1500, 2'b00, 4'b0, 3'b0, 0, 0, 0, 0, 0));
        wait_idle();
    endtask

    // run counter must stick at its maximum while the mode sits in avoid
    task automatic test_counter_saturation();
        int i;
        write_all_regs(400, 700, 0, 300, 150, 150, 80);
        while (arb_mode != MODE_LANE)
            send_snapshot(snap(500, 2'b00, AVF_DONE, PF_DONE, 0, 0, 65535, 100, 0));
        wait_idle();
        write_reg(CFG_HOLD_TICKS, 255);
        commit_writes();
        send_snapshot(snap(500, 2'b00, AVF_OBSTACLE | AVF_AVOIDABLE, 3'b0, 0, 0, 65535, 100, 0));
        for (i = 0; i < 300; i++)
            send_snapshot(snap(0, 2'b00, 4'b0, 3'b0, 0, 0, 65535, $urandom_range(0, 65535), 0));
        send_snapshot(snap(0, 2'b00, AVF_DONE, 3'b0, 0, 0, 65535, 100, 0));
        send_snapshot(snap(0, 2'b00, 4'b0, 3'b0, 0, 0, 65535, 100, 0));
        wait_idle();
    endtask

    // episodes of steady confidence with random events, plus pure noise
    task automatic run_episodes(input int count);
        int sent;
        int len;
        int i;
        bit noisy;
        conf_band_t band;
        sent = 0;
        while (sent < count)
        begin
            band = conf_band_t'($urandom_range(0, 3));
            len = $urandom_range(3, 30);
            noisy = chance(12);
            tx_steady = chance(20);
            for (i = 0; i < len; i++)
                send_snapshot(noisy ? noise_snapshot() : random_snapshot(band));
            sent += len;
        end
        tx_steady = 0;
    endtask

    task automatic test_random_phases();
        int phase;
        for (phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: write_all_regs(400, 700, 5, 300, 150, 150, 80);
                1: write_all_regs(0, 0, 0, 0, 0, 0, 0);
                2: write_all_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                  16'hFFFF);
                default:
                    write_all_regs(chance(25) ? $urandom_range(0, 65535) : $urandom_range(0, 600),
                                   chance(25) ? $urandom_range(0, 65535)
                                              : $urandom_range(500, 1024),
                                   ($urandom_range(0, 255) << 8) | $urandom_range(0, 8),
                                   $urandom_range(0, 65535), $urandom_range(0, 65535),
                                   $urandom_range(0, 3000), $urandom_range(0, 65535));
            endcase
            run_episodes(PHASE_SIZE);
            wait_idle();
        end
    endtask

    // receiver holds off while the sender keeps offering back to back
    task automatic test_backpressure();
        int i;
        write_all_regs(400, 700, 3, 300, 150, 150, 80);
        hold_asked++;
        tx_steady = 1;
        for (i = 0; i < 40; i++)
            send_snapshot(random_snapshot(conf_band_t'($urandom_range(0, 3))));
        tx_steady = 0;
        wait_idle();
    endtask

    // receiver ready pattern, with long hold-offs on request
    always @(posedge clk)
    begin
        if (rx_hold_left > 0)
        begin
            out_ready <= 1'b0;
            rx_hold_left <= rx_hold_left - 1;
        end
        else if (hold_served != hold_asked)
        begin
            out_ready <= 1'b0;
            rx_hold_left <= LONG_HOLD - 1;
            hold_served <= hold_served + 1;
        end
        else
        begin
            if (rx_left == 0)
            begin
                rx_style <= rx_style_t'($urandom_range(0, 3));
                rx_left <= $urandom_range(16, 96);
            end
            else
                rx_left <= rx_left - 1;
            case (rx_style)
                RX_ALWAYS: out_ready <= 1'b1;
                RX_MOSTLY: out_ready <= ($urandom_range(0, 9) < 8);
                RX_SPARSE: out_ready <= ($urandom_range(0, 9) < 3);
                default:   out_ready <= ~out_ready;
            endcase
        end
    end

    // compare each result transaction with the oldest expectation
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_valid === 1'b1 && out_ready === 1'b1)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t unexpected result: expected none actual mode %0d speed %0d stop %0d",
                         $time, mode, speed_ref, hard_stop);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (mode !== want.mode)
                begin
                    $display("%0t mode mismatch: expected %0d actual %0d",
                             $time, want.mode, mode);
                    error_count++;
                end
                if (speed_ref !== want.speed_ref)
                begin
                    $display("%0t speed_ref mismatch: expected %0d actual %0d",
                             $time, want.speed_ref, speed_ref);
                    error_count++;
                end
                if (hard_stop !== want.hard_stop)
                begin
                    $display("%0t hard_stop mismatch: expected %0d actual %0d",
                             $time, want.hard_stop, hard_stop);
                    error_count++;
                end
            end
        end
    end

    // overall time limit
    initial
    begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        lane_confidence = '0;
        zone_flags = '0;
        avoid_flags = '0;
        parking_flags = '0;
        emergency_stop = 1'b0;
        traffic_stop = 1'b0;
        time_to_collision = '0;
        avoid_speed = '0;
        parking_speed = '0;
        out_ready = 1'b0;
        error_count = 0;
        tx_burst_left = 0;
        tx_steady = 0;
        hold_asked = 0;
        hold_served = 0;
        rx_hold_left = 0;
        rx_left = 0;
        rx_style = RX_ALWAYS;
        arb_regs.conf_exit_level   = RST_CONF_EXIT;
        arb_regs.conf_return_level = RST_CONF_RETURN;
        arb_regs.hold_ticks        = RST_HOLD_TICKS;
        arb_regs.accel_speed       = RST_ACCEL_SPEED;
        arb_regs.base_speed        = RST_BASE_SPEED;
        arb_regs.ttc_stop_level    = RST_TTC_STOP;
        arb_regs.narrow_gap_speed  = RST_NARROW_SPEED;
        arb_mode = MODE_LANE;
        arb_return = RET_LANE;
        low_run = '0;
        high_run = '0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_modes();
        test_register_masking();
        test_counter_saturation();
        test_random_phases();
        test_backpressure();

        repeat (20) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            $display("%0t results missing: expected %0d more actual 0",
                     $time, pending_results.size());
            error_count++;
        end
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

[sim.f]
src/dmarb_pkg.sv
src/dmarb_cfg_regs.sv
src/dmarb_core.sv
src/driving_mode_arbiter_top.sv
verif/tb_driving_mode_arbiter_top.sv
